// ===== rtl/core/gap_pkg.sv =====
`timescale 1ns / 1ps
package gap_pkg;
    localparam int COORD_W   = 3;
    localparam int IDX_W     = 6;
    localparam int COST_W    = 6;
    localparam int DIR_W     = 2;
    localparam int CNT_W     = 7;
    localparam int F_W       = 7;
    localparam int MAX_CELLS = 64;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [COST_W-1:0]  t_cost;
    typedef logic [DIR_W-1:0]   t_dir;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam t_dir DIR_EAST  = 2'd0;
    localparam t_dir DIR_SOUTH = 2'd1;
    localparam t_dir DIR_WEST  = 2'd2;
    localparam t_dir DIR_NORTH = 2'd3;

    typedef struct packed {
        logic   cmd;
        t_coord cell_row;
        t_coord cell_col;
        logic   blocked;
        t_coord start_row;
        t_coord start_col;
        t_coord goal_row;
        t_coord goal_col;
    } t_in_item;

    typedef struct packed {
        t_coord path_row;
        t_coord path_col;
        logic   found;
        logic   last;
    } t_out_item;

    typedef struct packed {
        t_cost cost;
        t_dir  dir;
    } t_node;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_pos;

    typedef enum logic [3:0] {
        OP_IDLE, OP_LOAD, OP_INIT, OP_SCAN_CLR, OP_SCAN, OP_PICK, OP_NB_RD, OP_NB_UPD,
        OP_GOAL_RD, OP_LEN, OP_BT_WR, OP_BT_STEP, OP_EMIT_RD, OP_EMIT_LD, OP_NF
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic bad_coord;
        logic scan_done;
        logic have_best;
        logic best_is_goal;
        logic nb_last;
        logic k_zero;
        logic bt_break;
        logic emit_last;
        logic out_free;
    } t_dp_status;
endpackage

// ===== rtl/core/gap_if.sv =====
`timescale 1ns / 1ps
interface gap_in_if import gap_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gap_out_if import gap_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/gap_ctrl.sv =====
`timescale 1ns / 1ps
module gap_ctrl import gap_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_cmd,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);
    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_SCAN_CLR = 14'b00000000000010,
        S_SCAN     = 14'b00000000000100,
        S_PICK     = 14'b00000000001000,
        S_NB_RD    = 14'b00000000010000,
        S_NB_UPD   = 14'b00000000100000,
        S_GOAL_RD  = 14'b00000001000000,
        S_LEN      = 14'b00000010000000,
        S_BT_WR    = 14'b00000100000000,
        S_BT_STEP  = 14'b00001000000000,
        S_EMIT_RD  = 14'b00010000000000,
        S_EMIT_LD  = 14'b00100000000000,
        S_NF       = 14'b01000000000000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_IDLE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_cmd == CMD_LOAD) begin
                        o_cmd.op = OP_LOAD;
                    end else if (i_status.bad_coord) begin
                        n_state = S_NF;
                    end else begin
                        o_cmd.op = OP_INIT;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN_CLR: begin
                o_cmd.op = OP_SCAN_CLR;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_status.scan_done) begin
                    if (!i_status.have_best)        n_state = S_NF;
                    else if (i_status.best_is_goal) n_state = S_GOAL_RD;
                    else                            n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.op = OP_PICK;
                n_state  = S_NB_RD;
            end
            S_NB_RD: begin
                o_cmd.op = OP_NB_RD;
                n_state  = S_NB_UPD;
            end
            S_NB_UPD: begin
                o_cmd.op = OP_NB_UPD;
                n_state  = i_status.nb_last ? S_SCAN_CLR : S_NB_RD;
            end
            S_GOAL_RD: begin
                o_cmd.op = OP_GOAL_RD;
                n_state  = S_LEN;
            end
            S_LEN: begin
                o_cmd.op = OP_LEN;
                n_state  = S_BT_WR;
            end
            S_BT_WR: begin
                o_cmd.op = OP_BT_WR;
                n_state  = i_status.k_zero ? S_EMIT_RD : S_BT_STEP;
            end
            S_BT_STEP: begin
                o_cmd.op = OP_BT_STEP;
                n_state  = i_status.bt_break ? S_EMIT_RD : S_BT_WR;
            end
            S_EMIT_RD: begin
                o_cmd.op = OP_EMIT_RD;
                n_state  = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_cmd.op = OP_EMIT_LD;
                if (i_status.out_free) begin
                    n_state = i_status.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_NF: begin
                o_cmd.op = OP_NF;
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

// ===== rtl/core/gap_datapath.sv =====
`timescale 1ns / 1ps
module gap_datapath import gap_pkg::*; #(
    parameter int GRID_ROWS = 8,
    parameter int GRID_COLS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_item   i_item,
    input  logic       i_out_ready,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_item  o_out_item
);
    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam logic [COORD_W:0] ROWS_L = (COORD_W+1)'(GRID_ROWS);
    localparam logic [COORD_W:0] COLS_L = (COORD_W+1)'(GRID_COLS);
    localparam t_idx             COLS_I = IDX_W'(GRID_COLS);

    t_node r_node_mem [MAX_CELLS];
    t_pos  r_pbuf_mem [MAX_CELLS];
    t_node r_node_q;
    t_pos  r_pbuf_q;

    logic [MAX_CELLS-1:0] r_occ, r_known, r_open;

    // scan pipeline
    logic [CNT_W-1:0] r_s;
    t_coord           r_sr, r_sc, r_rd_r, r_rd_c;
    t_idx             r_rd_idx;
    logic             r_rd_vld;

    logic             r_have_best;
    t_idx             r_best_idx;
    t_coord           r_best_r, r_best_c;
    logic [F_W-1:0]   r_best_f;
    t_cost            r_best_g;

    t_coord           r_goal_r, r_goal_c;
    t_idx             r_goal_idx;
    t_cost            r_g;
    t_dir             r_d;
    t_idx             r_nb_idx;
    logic             r_nb_ok;

    t_cost            r_k;
    t_idx             r_e;
    logic [CNT_W-1:0] r_len;
    t_idx             r_cur;
    t_coord           r_cur_r, r_cur_c;

    logic             r_out_vld;
    t_out_item        r_out;

    logic             w_scan_issue;
    logic [COORD_W:0] w_hr, w_hc;
    logic [F_W-1:0]   w_f;
    logic             w_better;
    t_idx             w_nb_idx;
    logic             w_nb_in;
    logic             w_bt_ok;
    t_idx             w_prev_idx;
    t_coord           w_prev_r, w_prev_c;
    logic             w_out_free;
    logic             w_out_load;
    logic             w_emit_last;
    t_idx             w_start_idx, w_goal_idx;

    assign w_scan_issue = (r_s < CNT_W'(CELLS));
    assign w_out_free   = !r_out_vld || i_out_ready;
    assign w_out_load   = ((i_cmd.op == OP_EMIT_LD) || (i_cmd.op == OP_NF)) && w_out_free;
    assign w_emit_last  = ((CNT_W'(r_e) + 1'b1) == r_len);
    assign w_start_idx  = IDX_W'(i_item.start_row) * COLS_I + IDX_W'(i_item.start_col);
    assign w_goal_idx   = IDX_W'(i_item.goal_row) * COLS_I + IDX_W'(i_item.goal_col);

    always_comb begin
        w_hr = (r_rd_r > r_goal_r) ? {1'b0, r_rd_r - r_goal_r} : {1'b0, r_goal_r - r_rd_r};
        w_hc = (r_rd_c > r_goal_c) ? {1'b0, r_rd_c - r_goal_c} : {1'b0, r_goal_c - r_rd_c};
        w_f  = F_W'(r_node_q.cost) + F_W'(w_hr) + F_W'(w_hc);
        w_better = !r_have_best || (w_f < r_best_f)
                   || ((w_f == r_best_f) && (r_node_q.cost > r_best_g));
    end

    always_comb begin
        w_nb_idx = r_best_idx;
        w_nb_in  = 1'b0;
        case (r_d)
            DIR_EAST: begin
                w_nb_in  = ({1'b0, r_best_c} + 1'b1) < COLS_L;
                w_nb_idx = r_best_idx + 1'b1;
            end
            DIR_SOUTH: begin
                w_nb_in  = ({1'b0, r_best_r} + 1'b1) < ROWS_L;
                w_nb_idx = r_best_idx + COLS_I;
            end
            DIR_WEST: begin
                w_nb_in  = (r_best_c != '0);
                w_nb_idx = r_best_idx - 1'b1;
            end
            DIR_NORTH: begin
                w_nb_in  = (r_best_r != '0);
                w_nb_idx = r_best_idx - COLS_I;
            end
            default: w_nb_in = 1'b0;
        endcase
    end

    // step back against the direction that reached the current cell
    always_comb begin
        w_bt_ok    = 1'b0;
        w_prev_idx = r_cur;
        w_prev_r   = r_cur_r;
        w_prev_c   = r_cur_c;
        case (r_node_q.dir)
            DIR_EAST: begin
                w_bt_ok    = (r_cur_c != '0);
                w_prev_idx = r_cur - 1'b1;
                w_prev_c   = r_cur_c - 1'b1;
            end
            DIR_SOUTH: begin
                w_bt_ok    = (r_cur_r != '0);
                w_prev_idx = r_cur - COLS_I;
                w_prev_r   = r_cur_r - 1'b1;
            end
            DIR_WEST: begin
                w_bt_ok    = ({1'b0, r_cur_c} + 1'b1) < COLS_L;
                w_prev_idx = r_cur + 1'b1;
                w_prev_c   = r_cur_c + 1'b1;
            end
            DIR_NORTH: begin
                w_bt_ok    = ({1'b0, r_cur_r} + 1'b1) < ROWS_L;
                w_prev_idx = r_cur + COLS_I;
                w_prev_r   = r_cur_r + 1'b1;
            end
            default: w_bt_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_status.bad_coord    = ({1'b0, i_item.start_row} >= ROWS_L)
                              || ({1'b0, i_item.start_col} >= COLS_L)
                              || ({1'b0, i_item.goal_row} >= ROWS_L)
                              || ({1'b0, i_item.goal_col} >= COLS_L);
        o_status.scan_done    = !w_scan_issue && !r_rd_vld;
        o_status.have_best    = r_have_best;
        o_status.best_is_goal = (r_best_idx == r_goal_idx);
        o_status.nb_last      = (r_d == DIR_NORTH);
        o_status.k_zero       = (r_k == '0);
        o_status.bt_break     = !w_bt_ok;
        o_status.emit_last    = w_emit_last;
        o_status.out_free     = w_out_free;
    end

    // node store: cost and parent direction
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_INIT: r_node_mem[w_start_idx] <= '{cost: '0, dir: DIR_EAST};
            OP_NB_UPD: begin
                if (r_nb_ok && (!r_known[r_nb_idx] || (r_g < r_node_q.cost))) begin
                    r_node_mem[r_nb_idx] <= '{cost: r_g, dir: r_d};
                end
            end
            default: ;
        endcase
        case (i_cmd.op)
            OP_SCAN:    if (w_scan_issue) r_node_q <= r_node_mem[r_s[IDX_W-1:0]];
            OP_NB_RD:   r_node_q <= r_node_mem[w_nb_idx];
            OP_GOAL_RD: r_node_q <= r_node_mem[r_goal_idx];
            OP_BT_WR:   r_node_q <= r_node_mem[r_cur];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_BT_WR) r_pbuf_mem[r_k] <= '{row: r_cur_r, col: r_cur_c};
        if (i_cmd.op == OP_EMIT_RD) r_pbuf_q <= r_pbuf_mem[r_e];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_known     <= '0;
            r_open      <= '0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
            r_s         <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (r_out_vld && i_out_ready && !w_out_load) r_out_vld <= 1'b0;
            case (i_cmd.op)
                OP_LOAD: begin
                    if (({1'b0, i_item.cell_row} < ROWS_L) && ({1'b0, i_item.cell_col} < COLS_L))
                        r_occ[IDX_W'(i_item.cell_row) * COLS_I + IDX_W'(i_item.cell_col)]
                            <= i_item.blocked;
                end
                OP_INIT: begin
                    r_known     <= {{(MAX_CELLS-1){1'b0}}, 1'b1} << w_start_idx;
                    r_open      <= {{(MAX_CELLS-1){1'b0}}, 1'b1} << w_start_idx;
                    r_goal_r    <= i_item.goal_row;
                    r_goal_c    <= i_item.goal_col;
                    r_goal_idx  <= w_goal_idx;
                    r_s         <= '0;
                    r_sr        <= '0;
                    r_sc        <= '0;
                    r_rd_vld    <= 1'b0;
                    r_have_best <= 1'b0;
                end
                OP_SCAN_CLR: begin
                    r_s         <= '0;
                    r_sr        <= '0;
                    r_sc        <= '0;
                    r_rd_vld    <= 1'b0;
                    r_have_best <= 1'b0;
                end
                OP_SCAN: begin
                    r_rd_vld <= w_scan_issue;
                    r_rd_idx <= r_s[IDX_W-1:0];
                    r_rd_r   <= r_sr;
                    r_rd_c   <= r_sc;
                    if (w_scan_issue) begin
                        r_s <= r_s + 1'b1;
                        if ({1'b0, r_sc} == COLS_L - 1'b1) begin
                            r_sc <= '0;
                            r_sr <= r_sr + 1'b1;
                        end else begin
                            r_sc <= r_sc + 1'b1;
                        end
                    end
                    if (r_rd_vld && r_open[r_rd_idx] && w_better) begin
                        r_have_best <= 1'b1;
                        r_best_idx  <= r_rd_idx;
                        r_best_r    <= r_rd_r;
                        r_best_c    <= r_rd_c;
                        r_best_f    <= w_f;
                        r_best_g    <= r_node_q.cost;
                    end
                end
                OP_PICK: begin
                    r_open[r_best_idx] <= 1'b0;
                    r_g                <= r_best_g + 1'b1;
                    r_d                <= DIR_EAST;
                end
                OP_NB_RD: begin
                    r_nb_idx <= w_nb_idx;
                    r_nb_ok  <= w_nb_in && !r_occ[w_nb_idx];
                end
                OP_NB_UPD: begin
                    if (r_nb_ok && (!r_known[r_nb_idx] || (r_g < r_node_q.cost))) begin
                        r_known[r_nb_idx] <= 1'b1;
                        r_open[r_nb_idx]  <= 1'b1;
                    end
                    r_d <= r_d + 1'b1;
                end
                OP_LEN: begin
                    r_len   <= CNT_W'(r_node_q.cost) + 1'b1;
                    r_k     <= r_node_q.cost;
                    r_e     <= '0;
                    r_cur   <= r_goal_idx;
                    r_cur_r <= r_goal_r;
                    r_cur_c <= r_goal_c;
                end
                OP_BT_STEP: begin
                    if (w_bt_ok) begin
                        r_cur   <= w_prev_idx;
                        r_cur_r <= w_prev_r;
                        r_cur_c <= w_prev_c;
                        r_k     <= r_k - 1'b1;
                    end
                end
                OP_EMIT_LD: begin
                    if (w_out_free) begin
                        r_out_vld <= 1'b1;
                        r_out     <= '{path_row: r_pbuf_q.row, path_col: r_pbuf_q.col,
                                       found: 1'b1, last: w_emit_last};
                        r_e       <= r_e + 1'b1;
                    end
                end
                OP_NF: begin
                    if (w_out_free) begin
                        r_out_vld <= 1'b1;
                        r_out     <= '{path_row: '0, path_col: '0, found: 1'b0, last: 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
endmodule

// ===== rtl/core/grid_astar_path_search.sv =====
`timescale 1ns / 1ps
// load beat: no result; search: each expansion scans all cells through the node store
// read port, then takes the pick, the four neighbours and the scan restart; once the goal
// is picked the path is walked back from the goal and emitted one cell at a time. a new
// beat is taken once the last result of the previous search sits in the output register.
// synchronous active-low reset marks every grid cell free and empties the output register.
module grid_astar_path_search import gap_pkg::*; #(
    parameter int GRID_ROWS = 8,
    parameter int GRID_COLS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gap_in_if.sink    i_in,
    gap_out_if.source o_out
);
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    gap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.data.cmd),
        .i_status   (w_status),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    gap_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_in.data),
        .i_out_ready (o_out.ready),
        .o_status    (w_status),
        .o_out_valid (o_out.valid),
        .o_out_item  (o_out.data)
    );
endmodule
